// ===== hdl/min_max_decimation_pyramid_defines.svh =====
// ----------------------------------------------------------------------------
// Min/max decimation pyramid: assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_DECIMATION_PYRAMID_DEFINES_SVH
`define MIN_MAX_DECIMATION_PYRAMID_DEFINES_SVH

// Generic property, sampled on clk_i, ignored while rst_ni is low.
`define MMDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication.
`define MMDP_ASSERT_IMP(lbl, ante, cons, msg) \
  `MMDP_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define MMDP_ASSERT_NXT(lbl, ante, cons, msg) \
  `MMDP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== hdl/mmdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Min/max decimation pyramid: package
// Fixed field widths, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mmdp_pkg;

  localparam int unsigned LEVEL_W  = 4;   // level field of a result
  localparam int unsigned INDEX_W  = 24;  // block_index field of a result
  localparam int unsigned BASE_W   = 4;   // base_factor_log2 register
  localparam int unsigned LCOUNT_W = 5;   // level_count register
  localparam int unsigned CNT_W    = 32;  // sample counter
  localparam int unsigned LCMP_W   = 6;   // level compares, holds up to 63
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LOG2   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_CASCADE
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // take the sample on the input port
    logic step;    // emit one cascade entry into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic blk_end;   // offered sample closes a level-0 block
    logic done;      // current cascade entry is the last one
    logic out_free;  // output register can take an entry this cycle
  } dp_sts_t;

endpackage

// ===== hdl/min_max_decimation_pyramid.sv =====
// ----------------------------------------------------------------------------
// Min/max decimation pyramid: top level
// Streams signed samples in, streams min/max summary entries out.
// ----------------------------------------------------------------------------
// Each sample updates a running min and max; every 2^base_factor_log2
// samples (counted from the last restart) the block closes and a cascade
// of entries goes out: level 0 first, then each higher level whose
// earlier half was already waiting, up to level_count levels; the final
// entry of a cascade has tlast set. Trailing partial blocks never show up.
// A sample that closes a block holds the sample port until its cascade
// of 1 to level_count entries (a level_count of zero acting as one and
// anything above MAX_LEVELS capped there) is written out; the cascade
// walks the levels one per cycle through a single output register, and
// downstream stalls hold it.
// The sample port is ready again as soon as the cascade is written out,
// even while the last entry still waits in the output register.
// Configuration: cfg_index_i 0 is base_factor_log2 (cfg_data_i[3:0]),
// 1 is level_count (cfg_data_i[4:0]); write only while idle.
// ----------------------------------------------------------------------------
module min_max_decimation_pyramid #(
  parameter int unsigned MAX_LEVELS   = 16,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration write
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [mmdp_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [mmdp_pkg::LCOUNT_W-1:0]           cfg_data_i,
  // sample stream
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata: sample (signed), zero padded to bytes
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata_i,
  // tuser: restart
  input  logic                                    s_axis_tuser_i,
  // summary stream
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  // tdata: level[3:0], block_index[24], low peak, high peak, zero padded
  output logic [((mmdp_pkg::LEVEL_W+mmdp_pkg::INDEX_W+2*SAMPLE_WIDTH+7)/8)*8-1:0]
                                                  m_axis_tdata_o,
  output logic                                    m_axis_tlast_o
);
  import mmdp_pkg::*;

  localparam int unsigned OUT_W   = ((LEVEL_W + INDEX_W + 2*SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned FIELD_W = LEVEL_W + INDEX_W + 2*SAMPLE_WIDTH;

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic [LEVEL_W-1:0]             level;
  logic [INDEX_W-1:0]             block_index;
  logic signed [SAMPLE_WIDTH-1:0] lo_peak, hi_peak;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  // config registers never stall
  assign cfg_ready_o = 1'b1;
  assign sample      = s_axis_tdata_i[SAMPLE_WIDTH-1:0];

  mmdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mmdp_datapath #(
    .MAX_LEVELS   (MAX_LEVELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (sample),
    .restart_i     (s_axis_tuser_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .level_o       (level),
    .block_index_o (block_index),
    .lo_peak_o     (lo_peak),
    .hi_peak_o     (hi_peak),
    .last_o        (m_axis_tlast_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  // pack lowest field first, pad upper bits with zeros
  assign m_axis_tdata_o = OUT_W'({hi_peak, lo_peak, block_index, level}) &
                          {{(OUT_W-FIELD_W){1'b0}}, {FIELD_W{1'b1}}};

endmodule

// ===== hdl/mmdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Min/max decimation pyramid: controller
// Takes samples while idle, then walks the cascade one entry per cycle while the output register is free.
// ----------------------------------------------------------------------------
`include "min_max_decimation_pyramid_defines.svh"

module mmdp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mmdp_pkg::dp_sts_t sts_i,
  output mmdp_pkg::dp_cmd_t cmd_o
);
  import mmdp_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.blk_end) begin
          state_d = ST_CASCADE;
        end
      end
      ST_CASCADE: begin
        cmd_o.step = sts_i.out_free;
        if (sts_i.out_free && sts_i.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `MMDP_ASSERT_NXT(a_blk_end_starts_cascade, cmd_o.accept && sts_i.blk_end, state_q == ST_CASCADE, "block end did not start a cascade")
  `MMDP_ASSERT_NXT(a_last_entry_ends_cascade, cmd_o.step && sts_i.done, state_q == ST_IDLE, "cascade did not end after its last entry")

endmodule

// ===== hdl/mmdp_datapath.sv =====
// ----------------------------------------------------------------------------
// Min/max decimation pyramid: datapath
// Config registers, sample counter, running and pending min/max, cascade
// merge and the output register.
// ----------------------------------------------------------------------------
`include "min_max_decimation_pyramid_defines.svh"

module mmdp_datapath #(
  parameter int unsigned MAX_LEVELS   = 16,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write
  input  logic                              cfg_we_i,
  input  logic [mmdp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mmdp_pkg::LCOUNT_W-1:0]     cfg_data_i,
  // input item
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_i,
  input  logic                              restart_i,
  // result item
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mmdp_pkg::LEVEL_W-1:0]      level_o,
  output logic [mmdp_pkg::INDEX_W-1:0]      block_index_o,
  output logic signed [SAMPLE_WIDTH-1:0]    lo_peak_o,
  output logic signed [SAMPLE_WIDTH-1:0]    hi_peak_o,
  output logic                              last_o,
  // control
  input  mmdp_pkg::dp_cmd_t                 cmd_i,
  output mmdp_pkg::dp_sts_t                 sts_o
);
  import mmdp_pkg::*;

  localparam int unsigned LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam logic signed [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [LCMP_W-1:0] MAX_LEVELS_C = LCMP_W'(MAX_LEVELS);

  // config
  logic [BASE_W-1:0]   base_q;
  logic [LCOUNT_W-1:0] lcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_W'(1);
      lcount_q <= LCOUNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE_LOG2:   base_q   <= cfg_data_i[BASE_W-1:0];
        CFG_LEVEL_COUNT: lcount_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stream state
  logic [CNT_W-1:0]               cnt_q;
  logic signed [SAMPLE_WIDTH-1:0] run_min_q, run_max_q;
  logic [MAX_LEVELS-1:0]          half_q;
  logic signed [SAMPLE_WIDTH-1:0] pend_min_q [MAX_LEVELS];
  logic signed [SAMPLE_WIDTH-1:0] pend_max_q [MAX_LEVELS];

  // cascade state
  logic [LW-1:0]                  lvl_q;
  logic [CNT_W-1:0]               blk_q;
  logic signed [SAMPLE_WIDTH-1:0] cas_min_q, cas_max_q;

  // output register
  logic                           out_valid_q;
  logic [LEVEL_W-1:0]             level_q;
  logic [INDEX_W-1:0]             index_q;
  logic signed [SAMPLE_WIDTH-1:0] omin_q, omax_q;
  logic                           last_q;

  // sample side
  logic [CNT_W-1:0]               idx, low_mask;
  logic signed [SAMPLE_WIDTH-1:0] rmin, rmax;
  logic                           blk_end;

  always_comb begin
    idx      = restart_i ? '0 : cnt_q;
    low_mask = (CNT_W'(1) << base_q) - CNT_W'(1);
    blk_end  = (idx & low_mask) == low_mask;
    if (restart_i) begin
      rmin = sample_i;
      rmax = sample_i;
    end else begin
      rmin = (sample_i < run_min_q) ? sample_i : run_min_q;
      rmax = (sample_i > run_max_q) ? sample_i : run_max_q;
    end
  end

  // cascade side
  logic [LCMP_W-1:0]              levels_eff;
  logic                           lvl_ok;
  logic                           have_half;
  logic signed [SAMPLE_WIDTH-1:0] pmin, pmax;

  always_comb begin
    if (lcount_q == '0) begin
      levels_eff = LCMP_W'(1);
    end else if (LCMP_W'(lcount_q) > MAX_LEVELS_C) begin
      levels_eff = MAX_LEVELS_C;
    end else begin
      levels_eff = LCMP_W'(lcount_q);
    end
    lvl_ok    = (LCMP_W'(lvl_q) + LCMP_W'(1)) < levels_eff;
    have_half = half_q[lvl_q];
    pmin      = pend_min_q[lvl_q];
    pmax      = pend_max_q[lvl_q];
  end

  assign sts_o.blk_end  = blk_end;
  assign sts_o.done     = !(lvl_ok && have_half);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      run_min_q   <= MOST_POS;
      run_max_q   <= MOST_NEG;
      half_q      <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        cnt_q <= idx + CNT_W'(1);
        if (restart_i) begin
          half_q <= '0;
        end
        if (blk_end) begin
          run_min_q <= MOST_POS;
          run_max_q <= MOST_NEG;
          lvl_q     <= '0;
        end else begin
          run_min_q <= rmin;
          run_max_q <= rmax;
        end
      end
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
        if (lvl_ok) begin
          half_q[lvl_q] <= !have_half;
        end
        if (lvl_ok && have_half) begin
          lvl_q <= lvl_q + LW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && blk_end) begin
      cas_min_q <= rmin;
      cas_max_q <= rmax;
      blk_q     <= idx >> base_q;
    end
    if (cmd_i.step) begin
      level_q <= LEVEL_W'(lvl_q);
      index_q <= blk_q[INDEX_W-1:0];
      omin_q  <= cas_min_q;
      omax_q  <= cas_max_q;
      last_q  <= !(lvl_ok && have_half);
      blk_q   <= blk_q >> 1;
      if (lvl_ok && have_half) begin
        // merge with the earlier half waiting at this level
        if (pmin < cas_min_q) cas_min_q <= pmin;
        if (pmax > cas_max_q) cas_max_q <= pmax;
      end else if (lvl_ok) begin
        pend_min_q[lvl_q] <= cas_min_q;
        pend_max_q[lvl_q] <= cas_max_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign level_o       = level_q;
  assign block_index_o = index_q;
  assign lo_peak_o     = omin_q;
  assign hi_peak_o     = omax_q;
  assign last_o        = last_q;

  `MMDP_ASSERT_IMP(a_step_needs_free_out, cmd_i.step, !out_valid_q || out_ready_i, "cascade step into a full output register")
  `MMDP_ASSERT_IMP(a_level_in_range, cmd_i.step, LCMP_W'(lvl_q) < levels_eff, "cascade level beyond level count")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_decimation_pyramid testbench
// Streams signed samples into the pyramid under several register settings,
// predicts every min/max summary entry in a local model of the block and
// checks each output item field by field, with random source and sink stalls.
// ----------------------------------------------------------------------------
module tb;

  import mmdp_pkg::*;

  localparam int unsigned LEVELS_MAX = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned OUT_W      = 64;
  localparam int unsigned CYCLE_CAP  = 2_000_000;
  localparam int unsigned SETTLE     = 4;

  localparam logic signed [SAMPLE_W-1:0] PEAK_HI = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] PEAK_LO = 16'sh8000;

  // one sample item as the source offers it
  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       restart;
  } sample_rec_t;

  // one summary entry of the pyramid
  typedef struct {
    logic [LEVEL_W-1:0]         lvl;
    logic [INDEX_W-1:0]         idx;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic                       last;
  } summary_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BASE_LOG2;
  logic [LCOUNT_W-1:0]   cfg_data  = '0;

  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [SAMPLE_W-1:0]   s_axis_tdata_i  = '0;  // sample
  logic                  s_axis_tuser_i  = 1'b0;  // restart

  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // level[3:0], block_index[27:4], low peak[43:28], high peak[59:44], zero pad
  logic [OUT_W-1:0]      m_axis_tdata_o;
  logic                  m_axis_tlast_o;

  min_max_decimation_pyramid #(
    .MAX_LEVELS  (LEVELS_MAX),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #6 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Local model of the pyramid: its own register copy and stream state.
  // --------------------------------------------------------------------------
  logic [BASE_W-1:0]          base_log2 = 4'd1;
  logic [LCOUNT_W-1:0]        level_cnt = 5'd1;
  logic [CNT_W-1:0]           sample_cnt = '0;
  logic signed [SAMPLE_W-1:0] run_min = PEAK_HI;
  logic signed [SAMPLE_W-1:0] run_max = PEAK_LO;
  logic signed [SAMPLE_W-1:0] hold_min [LEVELS_MAX];
  logic signed [SAMPLE_W-1:0] hold_max [LEVELS_MAX];
  logic [LEVELS_MAX-1:0]      half_mask = '0;

  sample_rec_t sample_q [$];   // items waiting for the driver
  summary_t    summary_q [$];  // entries the block still owes us

  bit          idle_on     = 1'b1;
  bit          s_hit       = 1'b0;  // sample item taken at the last rising edge
  int unsigned src_gap     = 0;
  int unsigned snk_gap     = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_cnt   = 0;

  // Feed one accepted sample through the model and queue the entries it causes.
  task automatic pyramid_step(input sample_rec_t rec);
    logic [CNT_W-1:0]           pos;
    logic [CNT_W-1:0]           low_mask;
    logic [CNT_W-1:0]           blk;
    logic signed [SAMPLE_W-1:0] cmin;
    logic signed [SAMPLE_W-1:0] cmax;
    int                         depth;
    int                         l;
    bit                         fin;
    summary_t                   e;
    // restart wipes the stream state first, then the sample counts as index 0
    if (rec.restart) begin
      sample_cnt = '0;
      run_min    = PEAK_HI;
      run_max    = PEAK_LO;
      half_mask  = '0;
    end
    if (rec.value < run_min) run_min = rec.value;
    if (rec.value > run_max) run_max = rec.value;
    pos        = sample_cnt;
    sample_cnt = sample_cnt + 1;
    low_mask   = (32'd1 << base_log2) - 32'd1;
    if ((pos & low_mask) == low_mask) begin
      blk     = pos >> base_log2;
      cmin    = run_min;
      cmax    = run_max;
      run_min = PEAK_HI;
      run_max = PEAK_LO;
      // zero levels acts as one, anything past the top saturates
      depth = (level_cnt == 0) ? 1 : ((level_cnt > LEVELS_MAX) ? LEVELS_MAX : int'(level_cnt));
      l   = 0;
      fin = 1'b0;
      while (!fin) begin
        e.lvl = 4'(l);
        e.idx = 24'(blk >> l);
        e.lo  = cmin;
        e.hi  = cmax;
        fin   = 1'b1;
        if (l + 1 < depth) begin
          if (half_mask[l]) begin
            // second half arrived: merge and climb one level
            if (hold_min[l] < cmin) cmin = hold_min[l];
            if (hold_max[l] > cmax) cmax = hold_max[l];
            half_mask[l] = 1'b0;
            fin = 1'b0;
          end else begin
            hold_min[l]  = cmin;
            hold_max[l]  = cmax;
            half_mask[l] = 1'b1;
          end
        end
        e.last = fin;
        summary_q.insert(summary_q.size(), e);
        l++;
      end
    end
  endtask

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("[%0t] %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: all handshakes are sampled at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    summary_t got;
    summary_t want;
    s_hit = 1'b0;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        case (cfg_index)
          CFG_BASE_LOG2:   base_log2 = cfg_data[BASE_W-1:0];
          CFG_LEVEL_COUNT: level_cnt = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        s_hit = 1'b1;
        pyramid_step('{value: s_axis_tdata_i, restart: s_axis_tuser_i});
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.lvl  = m_axis_tdata_o[3:0];
        got.idx  = m_axis_tdata_o[27:4];
        got.lo   = m_axis_tdata_o[43:28];
        got.hi   = m_axis_tdata_o[59:44];
        got.last = m_axis_tlast_o;
        if (summary_q.size() == 0) begin
          note_fault($sformatf("unexpected entry: level %0d index %0d min %0d max %0d last %0b",
                               got.lvl, got.idx, got.lo, got.hi, got.last));
        end else begin
          want = summary_q.pop_front();
          if (got.lvl !== want.lvl || got.idx !== want.idx || got.lo !== want.lo ||
              got.hi !== want.hi || got.last !== want.last)
            note_fault($sformatf({"entry mismatch: exp level %0d index %0d min %0d max %0d ",
                                  "last %0b, got level %0d index %0d min %0d max %0d last %0b"},
                                 want.lvl, want.idx, want.lo, want.hi, want.last,
                                 got.lvl, got.idx, got.lo, got.hi, got.last));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("min_max_decimation_pyramid test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: source and sink change at the falling edge. A held item stays
  // put until taken; idle bursts only start between items.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    sample_rec_t rec;
    if (rst_ni) begin
      if (s_axis_tvalid_i && !s_hit) begin
        // still waiting for tready
      end else if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (sample_q.size() != 0) begin
        if (idle_on && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 18);
          s_axis_tvalid_i <= 1'b0;
        end else begin
          rec = sample_q.pop_front();
          s_axis_tdata_i  <= rec.value;
          s_axis_tuser_i  <= rec.restart;
          s_axis_tvalid_i <= 1'b1;
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(0, 18);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [LCOUNT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic push(input logic signed [SAMPLE_W-1:0] value, input logic restart);
    sample_rec_t rec;
    rec.value   = value;
    rec.restart = restart;
    sample_q.insert(sample_q.size(), rec);
  endtask

  // Wait until every item went in and every owed entry came out.
  task automatic drain();
    while (sample_q.size() != 0 || s_axis_tvalid_i || summary_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Extremes show up often so peaks land on both rails.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return PEAK_LO;
      1:       return PEAK_HI;
      2:       return 16'($urandom_range(0, 1) ? -1 : 0);
      default: return 16'($urandom);
    endcase
  endfunction

  // restart_odds of 0 means no restarts after the optional first one
  task automatic run_phase(input logic [BASE_W-1:0] base, input logic [LCOUNT_W-1:0] lvls,
                           input int count, input bit fresh, input int unsigned restart_odds);
    write_reg(CFG_BASE_LOG2, {1'b0, base});
    write_reg(CFG_LEVEL_COUNT, lvls);
    for (int i = 0; i < count; i++)
      push(pick_sample(), (fresh && i == 0) ||
           (restart_odds != 0 && $urandom_range(1, restart_odds) == 1));
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: pairs of samples, one level; rails, then a restart
    // landing on the second sample of a block
    push(PEAK_HI, 1'b0);
    push(PEAK_LO, 1'b0);
    push(16'sd5, 1'b0);
    push(-16'sd7, 1'b1);
    push(16'sd100, 1'b0);
    push(16'sd0, 1'b0);
    push(-16'sd1, 1'b0);
    drain();

    // one-sample blocks, zero levels acts as one
    write_reg(CFG_BASE_LOG2, 5'd0);
    write_reg(CFG_LEVEL_COUNT, 5'd0);
    push(16'sd3, 1'b1);
    push(PEAK_LO, 1'b0);
    push(PEAK_HI, 1'b0);
    drain();

    // four levels: the eighth sample closes a full four-entry cascade
    write_reg(CFG_LEVEL_COUNT, 5'd4);
    push(16'sd1, 1'b1);
    push(PEAK_HI, 1'b0);
    push(-16'sd2, 1'b0);
    push(16'sd4, 1'b0);
    push(PEAK_LO, 1'b0);
    push(16'sd0, 1'b0);
    push(16'sh5555, 1'b0);
    push(-16'sh5556, 1'b0);
    drain();

    // level count past the top saturates; no restart, so old halves carry over
    write_reg(CFG_BASE_LOG2, 5'd2);
    write_reg(CFG_LEVEL_COUNT, 5'd31);
    for (int i = 0; i < 8; i++) push(pick_sample(), 1'b0);
    drain();

    // random settings, switched mid-stream between phases
    for (int p = 0; p < 5; p++)
      run_phase(4'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), 70, 1'b0, 40);

    // last part, no stalls: a seven-entry cascade on the 64th sample, then
    // the widest block, left partial so it never shows up
    idle_on = 1'b0;
    run_phase(4'd0, 5'd16, 64, 1'b1, 0);
    run_phase(4'd15, 5'd17, 30, 1'b1, 0);

    repeat (20) @(posedge clk_i);
    if (fault_count == 0 && summary_q.size() == 0)
      $display("min_max_decimation_pyramid test passed");
    else
      $display("min_max_decimation_pyramid test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mmdp_pkg.sv
hdl/mmdp_ctrl.sv
hdl/mmdp_datapath.sv
hdl/min_max_decimation_pyramid.sv
test/tb.sv
